// ===== rtl/core/crd_pkg.sv =====
// shared types and constants for the caption record deframer
`default_nettype none
package crd_pkg;

  localparam int FRAME_W = 24;
  localparam int LEN_W   = 14;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int CODE_W  = 3;
  localparam int Q_DEPTH = 2;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd3;

  localparam logic [CODE_W-1:0] ERR_TRUNC_HDR = 3'd0;
  localparam logic [CODE_W-1:0] ERR_BAD_HDR   = 3'd1;
  localparam logic [CODE_W-1:0] ERR_TRUNC_LEN = 3'd2;
  localparam logic [CODE_W-1:0] ERR_BAD_LEN   = 3'd3;
  localparam logic [CODE_W-1:0] ERR_TRUNC_PAY = 3'd4;

  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 14'd9999;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FRAME_W-1:0] frame_number;
    logic [LEN_W-1:0]   payload_length;
    logic [BYTE_W-1:0]  payload_byte;
    logic               last;
    logic [CODE_W-1:0]  error_code;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/crd_if.sv =====
// stream channel interfaces for the deframer input and result sides
`default_nettype none
interface crd_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [crd_pkg::BYTE_W-1:0] data_byte;
  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface crd_out_if;
  logic                        valid;
  logic                        ready;
  logic [crd_pkg::KIND_W-1:0]  kind;
  logic [crd_pkg::FRAME_W-1:0] frame_number;
  logic [crd_pkg::LEN_W-1:0]   payload_length;
  logic [crd_pkg::BYTE_W-1:0]  payload_byte;
  logic                        last;
  logic [crd_pkg::CODE_W-1:0]  error_code;
  modport source (output valid, output kind, output frame_number, output payload_length,
                  output payload_byte, output last, output error_code, input ready);
  modport sink (input valid, input kind, input frame_number, input payload_length,
                input payload_byte, input last, input error_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/crd_front.sv =====
// front end: accepts stream bytes, parses record headers, produces result items
`default_nettype none
module crd_front #(
  parameter int FRAME_DIGITS  = 7,
  parameter int LENGTH_DIGITS = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  crd_in_if.sink                          in_ch,
  input  wire logic                       cfg_we,
  input  wire logic [crd_pkg::LEN_W-1:0]  cfg_wdata,
  input  wire logic                       q_full,
  output logic                            q_push,
  output crd_pkg::res_t                   q_data
);

  localparam int MAX_DIGITS = (FRAME_DIGITS > LENGTH_DIGITS) ? FRAME_DIGITS : LENGTH_DIGITS;
  localparam int POS_W      = $clog2(MAX_DIGITS + 1);
  localparam logic [POS_W-1:0] FRAME_POS = POS_W'(FRAME_DIGITS);
  localparam logic [POS_W-1:0] LEN_POS   = POS_W'(LENGTH_DIGITS);

  typedef enum logic [1:0] {PH_HEADER, PH_LENGTH, PH_PAYLOAD, PH_ERROR} phase_t;
  typedef enum logic [2:0] {ST_LEAD, ST_MINUS, ST_DIGITS, ST_TRAIL, ST_BAD} stage_t;

  phase_t                      phase_r, phase_nxt;
  stage_t                      stage_r, stage_nxt, scan_stage;
  logic [POS_W-1:0]            pos_r, pos_nxt, pos_inc;
  logic                        minus_r, minus_nxt, scan_minus;
  logic                        nz_r, nz_nxt, scan_nz;
  logic [crd_pkg::FRAME_W-1:0] acc_r, acc_nxt, scan_acc;
  logic [crd_pkg::FRAME_W-1:0] held_r, held_nxt;
  logic [crd_pkg::LEN_W-1:0]   rem_r, rem_nxt, rem_dec;
  logic [crd_pkg::LEN_W-1:0]   max_r;
  logic                        in_fire;
  logic                        is_space, is_digit;
  logic [crd_pkg::FRAME_W-1:0] digit;
  logic                        cur_ok, scan_ok;
  logic                        push_nxt;
  crd_pkg::res_t               res_nxt;

  assign in_ch.ready = !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign pos_inc     = pos_r + POS_W'(1);
  assign rem_dec     = rem_r - crd_pkg::LEN_W'(1);

  // character scan of one numeric field byte
  always_comb begin
    is_space = (in_ch.data_byte == crd_pkg::CHAR_SPACE) ||
               ((in_ch.data_byte >= crd_pkg::CHAR_TAB) && (in_ch.data_byte <= crd_pkg::CHAR_CR));
    is_digit = (in_ch.data_byte >= crd_pkg::CHAR_ZERO) && (in_ch.data_byte <= crd_pkg::CHAR_NINE);
    digit    = crd_pkg::FRAME_W'(in_ch.data_byte - crd_pkg::CHAR_ZERO);
    scan_stage = stage_r;
    scan_minus = minus_r;
    scan_nz    = nz_r;
    scan_acc   = acc_r;
    if (is_space) begin
      if (stage_r == ST_MINUS) begin
        scan_stage = ST_BAD;
      end else if (stage_r == ST_DIGITS) begin
        scan_stage = ST_TRAIL;
      end
    end else if (in_ch.data_byte == crd_pkg::CHAR_MINUS) begin
      if (stage_r == ST_LEAD) begin
        scan_stage = ST_MINUS;
        scan_minus = 1'b1;
      end else begin
        scan_stage = ST_BAD;
      end
    end else if (is_digit) begin
      if (stage_r == ST_LEAD || stage_r == ST_MINUS || stage_r == ST_DIGITS) begin
        scan_stage = ST_DIGITS;
        scan_acc   = (acc_r << 3) + (acc_r << 1) + digit;
        if (digit != '0) begin
          scan_nz = 1'b1;
        end
      end else begin
        scan_stage = ST_BAD;
      end
    end else begin
      scan_stage = ST_BAD;
    end
    cur_ok  = (stage_r == ST_DIGITS || stage_r == ST_TRAIL) && !(minus_r && nz_r);
    scan_ok = (scan_stage == ST_DIGITS || scan_stage == ST_TRAIL) && !(scan_minus && scan_nz);
  end

  always_comb begin
    phase_nxt = phase_r;
    stage_nxt = stage_r;
    pos_nxt   = pos_r;
    minus_nxt = minus_r;
    nz_nxt    = nz_r;
    acc_nxt   = acc_r;
    held_nxt  = held_r;
    rem_nxt   = rem_r;
    push_nxt  = 1'b0;
    res_nxt   = '0;
    if (in_fire) begin
      if (in_ch.op) begin
        phase_nxt = PH_HEADER;
        stage_nxt = ST_LEAD;
        pos_nxt   = '0;
        minus_nxt = 1'b0;
        nz_nxt    = 1'b0;
        acc_nxt   = '0;
        rem_nxt   = '0;
        unique case (phase_r)
          PH_HEADER: begin
            push_nxt         = 1'b1;
            res_nxt.kind     = (pos_r == '0) ? crd_pkg::KIND_END : crd_pkg::KIND_ERROR;
            res_nxt.error_code = crd_pkg::ERR_TRUNC_HDR;
          end
          PH_LENGTH: begin
            push_nxt           = 1'b1;
            res_nxt.kind       = crd_pkg::KIND_ERROR;
            res_nxt.error_code = crd_pkg::ERR_TRUNC_LEN;
          end
          PH_PAYLOAD: begin
            push_nxt           = 1'b1;
            res_nxt.kind       = crd_pkg::KIND_ERROR;
            res_nxt.error_code = crd_pkg::ERR_TRUNC_PAY;
          end
          PH_ERROR: begin
            push_nxt = 1'b0;
          end
          default: begin
            push_nxt = 1'b0;
          end
        endcase
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            if (pos_r < FRAME_POS) begin
              stage_nxt = scan_stage;
              minus_nxt = scan_minus;
              nz_nxt    = scan_nz;
              acc_nxt   = scan_acc;
              pos_nxt   = pos_inc;
            end else if (in_ch.data_byte != crd_pkg::CHAR_COLON || !cur_ok) begin
              phase_nxt          = PH_ERROR;
              push_nxt           = 1'b1;
              res_nxt.kind       = crd_pkg::KIND_ERROR;
              res_nxt.error_code = crd_pkg::ERR_BAD_HDR;
            end else begin
              held_nxt  = acc_r;
              phase_nxt = PH_LENGTH;
              stage_nxt = ST_LEAD;
              pos_nxt   = '0;
              minus_nxt = 1'b0;
              nz_nxt    = 1'b0;
              acc_nxt   = '0;
            end
          end
          PH_LENGTH: begin
            stage_nxt = scan_stage;
            minus_nxt = scan_minus;
            nz_nxt    = scan_nz;
            acc_nxt   = scan_acc;
            pos_nxt   = pos_inc;
            if (pos_inc >= LEN_POS) begin
              if (!scan_ok || scan_acc > crd_pkg::FRAME_W'(max_r)) begin
                phase_nxt          = PH_ERROR;
                push_nxt           = 1'b1;
                res_nxt.kind       = crd_pkg::KIND_ERROR;
                res_nxt.error_code = crd_pkg::ERR_BAD_LEN;
              end else begin
                rem_nxt   = scan_acc[crd_pkg::LEN_W-1:0];
                stage_nxt = ST_LEAD;
                pos_nxt   = '0;
                minus_nxt = 1'b0;
                nz_nxt    = 1'b0;
                acc_nxt   = '0;
                push_nxt               = 1'b1;
                res_nxt.kind           = crd_pkg::KIND_START;
                res_nxt.frame_number   = held_r;
                res_nxt.payload_length = scan_acc[crd_pkg::LEN_W-1:0];
                if (scan_acc[crd_pkg::LEN_W-1:0] == '0) begin
                  phase_nxt    = PH_HEADER;
                  res_nxt.last = 1'b1;
                end else begin
                  phase_nxt = PH_PAYLOAD;
                end
              end
            end
          end
          PH_PAYLOAD: begin
            rem_nxt              = rem_dec;
            push_nxt             = 1'b1;
            res_nxt.kind         = crd_pkg::KIND_BYTE;
            res_nxt.payload_byte = in_ch.data_byte;
            if (rem_dec == '0) begin
              res_nxt.last = 1'b1;
              phase_nxt    = PH_HEADER;
            end
          end
          PH_ERROR: begin
            push_nxt = 1'b0;
          end
          default: begin
            push_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      stage_r <= ST_LEAD;
      pos_r   <= '0;
      minus_r <= 1'b0;
      nz_r    <= 1'b0;
      acc_r   <= '0;
      held_r  <= '0;
      rem_r   <= '0;
      max_r   <= crd_pkg::MAX_PAYLOAD_RST;
    end else begin
      phase_r <= phase_nxt;
      stage_r <= stage_nxt;
      pos_r   <= pos_nxt;
      minus_r <= minus_nxt;
      nz_r    <= nz_nxt;
      acc_r   <= acc_nxt;
      held_r  <= held_nxt;
      rem_r   <= rem_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  assign q_push = push_nxt;
  assign q_data = res_nxt;

endmodule
`default_nettype wire

// ===== rtl/core/crd_fifo.sv =====
// short result queue between the parser and the output stage
`default_nettype none
module crd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire crd_pkg::res_t push_data,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output crd_pkg::res_t      head
);

  localparam int PTR_W = $clog2(crd_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(crd_pkg::Q_DEPTH + 1);

  crd_pkg::res_t    slot_r [crd_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(crd_pkg::Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/crd_back.sv =====
// back end: output register that presents result items to the sink
`default_nettype none
module crd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_not_empty,
  input  wire crd_pkg::res_t q_head,
  output logic               q_pop,
  crd_out_if.source          out_ch
);

  logic          valid_r;
  crd_pkg::res_t res_r;

  assign q_pop = q_not_empty && (!valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_ch.ready) begin
      valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= q_head;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.kind           = res_r.kind;
  assign out_ch.frame_number   = res_r.frame_number;
  assign out_ch.payload_length = res_r.payload_length;
  assign out_ch.payload_byte   = res_r.payload_byte;
  assign out_ch.last           = res_r.last;
  assign out_ch.error_code     = res_r.error_code;

endmodule
`default_nettype wire

// ===== rtl/core/caption_record_deframer.sv =====
// top level of the caption record deframer
//
//  channel   direction  handshake        payload
//  in_ch     in         valid/ready      op, data_byte
//  out_ch    out        valid/ready      kind, frame_number, payload_length,
//                                        payload_byte, last, error_code
//  cfg_*     in         write enable     max_payload (14 bits)
//
// one byte per cycle while the result queue is not full; each accepted byte is parsed in the cycle it is taken
// a result reaches out_ch through the queue write and then the output register
// in_ch stalls only when the two-entry result queue is full
// rst_n is synchronous; max_payload returns to 9999 on reset
`default_nettype none
module caption_record_deframer #(
  parameter int FRAME_DIGITS  = 7,
  parameter int LENGTH_DIGITS = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  crd_in_if.sink                         in_ch,
  crd_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [crd_pkg::LEN_W-1:0] cfg_wdata
);

  logic          q_full, q_push, q_pop, q_not_empty;
  crd_pkg::res_t q_data, q_head;

  crd_front #(
    .FRAME_DIGITS  (FRAME_DIGITS),
    .LENGTH_DIGITS (LENGTH_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  crd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  crd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire
